### rtl/bea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bea_pkg;

   localparam int COORD_WIDTH   = 24;
   localparam int ANGLE_WIDTH   = 16;
   localparam int STEPS_DEFAULT = 16;
   localparam int ATAN_LEN      = 24;
   localparam int ACC_WIDTH     = 32;
   localparam int SCALED_WIDTH  = 40;
   localparam int GUARD_BITS    = SCALED_WIDTH - COORD_WIDTH;
   // Headroom for negation and CORDIC gain on the scaled coordinates.
   localparam int CALC_WIDTH    = SCALED_WIDTH + 4;
   localparam int QUEUE_DEPTH   = 4;
   localparam int ATAN_IDX_W    = $clog2(ATAN_LEN);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] offset_x;
      logic signed [COORD_WIDTH-1:0] offset_y;
      logic [ANGLE_WIDTH-1:0]        heading;
   } req_type;

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0]        bearing;
      logic signed [ANGLE_WIDTH-1:0] bearing_error;
   } rsp_type;

   typedef struct packed {
      logic signed [CALC_WIDTH-1:0] x;
      logic signed [CALC_WIDTH-1:0] y;
      logic [ACC_WIDTH-1:0]         z;
      logic                         is_zero;
      logic [ANGLE_WIDTH-1:0]       heading;
   } work_type;

   function automatic logic [ACC_WIDTH-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
      logic [ACC_WIDTH-1:0] val;
      case (idx)
         5'd0:    val = 32'h2000_0000;
         5'd1:    val = 32'h12E4_051E;
         5'd2:    val = 32'h09FB_385B;
         5'd3:    val = 32'h0511_11D4;
         5'd4:    val = 32'h028B_0D43;
         5'd5:    val = 32'h0145_D7E1;
         5'd6:    val = 32'h00A2_F61E;
         5'd7:    val = 32'h0051_7C55;
         5'd8:    val = 32'h0028_BE53;
         5'd9:    val = 32'h0014_5F2F;
         5'd10:   val = 32'h000A_2F98;
         5'd11:   val = 32'h0005_17CC;
         5'd12:   val = 32'h0002_8BE6;
         5'd13:   val = 32'h0001_45F3;
         5'd14:   val = 32'h0000_A2FA;
         5'd15:   val = 32'h0000_517D;
         5'd16:   val = 32'h0000_28BE;
         5'd17:   val = 32'h0000_145F;
         5'd18:   val = 32'h0000_0A30;
         5'd19:   val = 32'h0000_0518;
         5'd20:   val = 32'h0000_028C;
         5'd21:   val = 32'h0000_0146;
         5'd22:   val = 32'h0000_00A3;
         5'd23:   val = 32'h0000_0051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

### rtl/bea_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bea_front
   import bea_pkg::*;
(
   input  req_type  req_data,
   output work_type work
);

   logic signed [CALC_WIDTH-1:0] x_scaled;
   logic signed [CALC_WIDTH-1:0] y_scaled;

   assign x_scaled = {{(CALC_WIDTH - SCALED_WIDTH){req_data.offset_x[COORD_WIDTH-1]}},
                      req_data.offset_x, {GUARD_BITS{1'b0}}};
   assign y_scaled = {{(CALC_WIDTH - SCALED_WIDTH){req_data.offset_y[COORD_WIDTH-1]}},
                      req_data.offset_y, {GUARD_BITS{1'b0}}};

   // A vector in the left half plane is turned by a half turn first.
   always_comb begin
      work.heading = req_data.heading;
      work.is_zero = (req_data.offset_x == '0) && (req_data.offset_y == '0);
      if (req_data.offset_x[COORD_WIDTH-1]) begin
         work.x = -x_scaled;
         work.y = -y_scaled;
         work.z = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      end else begin
         work.x = x_scaled;
         work.y = y_scaled;
         work.z = '0;
      end
   end

endmodule

`default_nettype wire

### rtl/bea_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bea_queue
   import bea_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_data,
   output logic     full,
   input  logic     pop,
   output work_type head_data,
   output logic     empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("Request written into a full queue.");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("Request taken from an empty queue.");

endmodule

`default_nettype wire

### rtl/bea_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module bea_cordic
   import bea_pkg::*;
#(
   parameter int STEPS = STEPS_DEFAULT
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_work,
   output logic     in_ready,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam int DROP = ACC_WIDTH - ANGLE_WIDTH;

   work_type stg_ff     [STEPS];
   work_type stg_in     [STEPS];
   logic     stg_vld_ff [STEPS];
   logic     stg_rdy    [STEPS];
   logic     out_vld_ff;
   logic     out_ready;
   rsp_type  out_ff;
   rsp_type  out_in;

   logic [ACC_WIDTH-1:0]   z_rounded;
   logic [ANGLE_WIDTH-1:0] bearing_val;

   assign out_ready = !out_vld_ff || rsp_pop;
   assign in_ready  = stg_rdy[0];
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         work_type                     src;
         logic                         src_vld;
         logic signed [CALC_WIDTH-1:0] xs;
         logic signed [CALC_WIDTH-1:0] ys;

         if (i == 0) begin : g_first
            assign src     = in_work;
            assign src_vld = in_valid;
         end else begin : g_next
            assign src     = stg_ff[i-1];
            assign src_vld = stg_vld_ff[i-1];
         end

         if (i == STEPS - 1) begin : g_last_rdy
            assign stg_rdy[i] = !stg_vld_ff[i] || out_ready;
         end else begin : g_mid_rdy
            assign stg_rdy[i] = !stg_vld_ff[i] || stg_rdy[i+1];
         end

         assign xs = src.x >>> i;
         assign ys = src.y >>> i;

         always_comb begin
            stg_in[i].heading = src.heading;
            stg_in[i].is_zero = src.is_zero;
            if (!src.y[CALC_WIDTH-1]) begin
               stg_in[i].x = src.x + ys;
               stg_in[i].y = src.y - xs;
               stg_in[i].z = src.z + atan_turns(ATAN_IDX_W'(i));
            end else begin
               stg_in[i].x = src.x - ys;
               stg_in[i].y = src.y + xs;
               stg_in[i].z = src.z - atan_turns(ATAN_IDX_W'(i));
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stg_vld_ff[i] <= 1'b0;
            end else if (stg_rdy[i]) begin
               stg_vld_ff[i] <= src_vld;
            end
         end

         always_ff @(posedge clock) begin
            if (stg_rdy[i] && src_vld) begin
               stg_ff[i] <= stg_in[i];
            end
         end
      end
   endgenerate

   // Round to nearest at the output angle width; the sum wraps modulo a full turn.
   assign z_rounded   = stg_ff[STEPS-1].z + (ACC_WIDTH'(1) << (DROP - 1));
   assign bearing_val = stg_ff[STEPS-1].is_zero ? '0 : z_rounded[ACC_WIDTH-1 -: ANGLE_WIDTH];

   always_comb begin
      out_in.bearing       = bearing_val;
      out_in.bearing_error = signed'(bearing_val - stg_ff[STEPS-1].heading);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_ready) begin
         out_vld_ff <= stg_vld_ff[STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stg_vld_ff[STEPS-1]) begin
         out_ff <= out_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
                    (stg_vld_ff[STEPS-1] && out_ready) |=> out_vld_ff)
      else $error("Finished request was not moved into the output register.");

   assert property (@(posedge clock) disable iff (reset)
                    (stg_vld_ff[0] && !stg_rdy[0]) |=> stg_vld_ff[0])
      else $error("Stalled request left the first stage.");

endmodule

`default_nettype wire

### rtl/bearing_error_atan2_unit.sv
// Bearing and bearing error unit.
// A request carries a signed target offset (offset_x, offset_y) and the current
// heading. It is taken at a rising edge with req_push high and req_full low.
// Each request gives one response with the four-quadrant bearing of the offset
// and the bearing minus the heading, wrapped to plus or minus a half turn, both
// in binary angle units.
// Responses are presented in request order while rsp_empty is low and are taken
// at a rising edge with rsp_pop high.
// A request enters a four-entry queue, then a CORDIC pipeline of CORDIC_STEPS
// stages, then the output register.
// One request can be taken every cycle while req_full is low, set by the
// one-stage-per-iteration pipeline.
// When the receiver stalls, the pipeline and queue fill; req_full rises once
// CORDIC_STEPS + 5 requests are waiting.
// Reset empties the queue, the pipeline and the output register.
`timescale 1ns / 1ps
`default_nettype none

module bearing_error_atan2_unit
   import bea_pkg::*;
#(
   parameter int CORDIC_STEPS = STEPS_DEFAULT
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   work_type front_work;
   work_type queue_head;
   logic     queue_empty;
   logic     queue_full;
   logic     queue_pop;
   logic     back_ready;

   assign req_full  = queue_full;
   assign queue_pop = !queue_empty && back_ready;

   bea_front u_front (
      .req_data (req_data),
      .work     (front_work)
   );

   bea_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && !queue_full),
      .push_data (front_work),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_data (queue_head),
      .empty     (queue_empty)
   );

   bea_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!queue_empty),
      .in_work   (queue_head),
      .in_ready  (back_ready),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bea_pkg::*;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int RANDOM_COUNT = 450;
   localparam int DRAIN_CYCLES = STEPS_DEFAULT + 8;

   localparam bit [31:0] TURN_TABLE [ATAN_LEN] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
      32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
      32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
   };

   logic    clock;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   req_type target_q[$];
   rsp_type bearing_q[$];

   int  mismatch_count = 0;
   int  requests_sent = 0;
   int  responses_checked = 0;
   int  cycle_count = 0;
   int  push_idle = 0;
   int  pop_idle = 0;
   bit  push_calm = 0;
   bit  pop_calm = 0;

   bearing_error_atan2_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type predict_bearing(input req_type target);
      rsp_type   result;
      longint    x;
      longint    y;
      longint    xs;
      longint    ys;
      bit [31:0] acc;
      bit [31:0] rounded;
      x = longint'(target.offset_x);
      y = longint'(target.offset_y);
      result.bearing = '0;
      if (x != 0 || y != 0) begin
         x = x * (longint'(1) << GUARD_BITS);
         y = y * (longint'(1) << GUARD_BITS);
         acc = '0;
         if (x < 0) begin
            x = -x;
            y = -y;
            acc = 32'h8000_0000;
         end
         for (int i = 0; i < STEPS_DEFAULT && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               acc = acc + TURN_TABLE[i];
            end else begin
               x = x - ys;
               y = y + xs;
               acc = acc - TURN_TABLE[i];
            end
         end
         rounded = acc + (32'd1 << (31 - ANGLE_WIDTH));
         result.bearing = rounded[31 -: ANGLE_WIDTH];
      end
      result.bearing_error = result.bearing - target.heading;
      return result;
   endfunction

   function automatic req_type make_target(input int x, input int y, input int h);
      req_type target;
      target.offset_x = COORD_WIDTH'(x);
      target.offset_y = COORD_WIDTH'(y);
      target.heading  = ANGLE_WIDTH'(h);
      return target;
   endfunction

   function automatic int draw_idle(input bit calm);
      int pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 55) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 40);
   endfunction

   function automatic int small_coord();
      return int'($urandom_range(0, 40)) - 20;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch on response %0d: %s", responses_checked, what);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("bearing_error_atan2_unit test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            bearing_q.push_back(predict_bearing(req_data));
            void'(target_q.pop_front());
            requests_sent++;
         end
         if (req_push && req_full) begin
            // The request is held until the block takes it.
         end else if (push_idle > 0) begin
            push_idle--;
            req_push <= 1'b0;
         end else if (target_q.size() > 0) begin
            req_push <= 1'b1;
            req_data <= target_q[0];
            if ($urandom_range(0, 49) == 0) begin
               push_calm = ~push_calm;
            end
            push_idle = draw_idle(push_calm);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (bearing_q.size() == 0) begin
               report_mismatch($sformatf("response %0h arrived with nothing expected",
                                         rsp_data));
            end else begin
               want = bearing_q.pop_front();
               if (rsp_data.bearing !== want.bearing) begin
                  report_mismatch($sformatf("bearing got %0h expected %0h",
                                            rsp_data.bearing, want.bearing));
               end
               if (rsp_data.bearing_error !== want.bearing_error) begin
                  report_mismatch($sformatf("bearing_error got %0h expected %0h",
                                            rsp_data.bearing_error,
                                            want.bearing_error));
               end
            end
            responses_checked++;
         end
         if (pop_idle > 0) begin
            pop_idle--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 49) == 0) begin
               pop_calm = ~pop_calm;
            end
            pop_idle = draw_idle(pop_calm);
         end
      end
   end

   initial begin
      int kind;
      int mag;
      reset    = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop  = 1'b0;

      target_q.push_back(make_target(0, 0, 0));
      target_q.push_back(make_target(0, 0, 16'hFFFF));
      target_q.push_back(make_target(0, 0, 16'h8000));
      target_q.push_back(make_target(1, 0, 0));
      target_q.push_back(make_target(1, 0, 16'h8000));
      target_q.push_back(make_target(-1, 0, 0));
      target_q.push_back(make_target(-8388608, 0, 0));
      target_q.push_back(make_target(-5, 0, 16'hFFFF));
      target_q.push_back(make_target(0, -1, 0));
      target_q.push_back(make_target(0, -8388608, 16'h4000));
      target_q.push_back(make_target(0, 8388607, 16'hC000));
      target_q.push_back(make_target(8388607, 8388607, 16'h2000));
      target_q.push_back(make_target(-8388608, -8388608, 16'h1234));
      target_q.push_back(make_target(-8388608, 8388607, 16'hA000));
      target_q.push_back(make_target(8388607, -8388608, 16'h7FFF));
      target_q.push_back(make_target(8388607, -1, 0));
      target_q.push_back(make_target(-8388608, 1, 16'h8000));
      target_q.push_back(make_target(-8388608, -1, 16'h7FFF));
      target_q.push_back(make_target(-1, -1, 16'h5555));
      target_q.push_back(make_target(3, -3, 16'hAAAA));
      target_q.push_back(make_target(8388607, 0, 16'h8001));

      for (int n = 0; n < RANDOM_COUNT; n++) begin
         kind = $urandom_range(0, 3);
         case (kind)
            0: begin
               target_q.push_back(make_target($urandom, $urandom, $urandom));
            end
            1: begin
               target_q.push_back(make_target(small_coord(), small_coord(), $urandom));
            end
            2: begin
               mag = $urandom_range(0, 1) ? small_coord() : int'($urandom);
               if ($urandom_range(0, 1) != 0) begin
                  target_q.push_back(make_target(mag, 0, $urandom));
               end else begin
                  target_q.push_back(make_target(0, mag, $urandom));
               end
            end
            default: begin
               mag = int'($urandom_range(1, 8388607));
               target_q.push_back(make_target($urandom_range(0, 1) ? mag : -mag,
                                              $urandom_range(0, 1) ? mag : -mag,
                                              $urandom));
            end
         endcase
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (target_q.size() != 0) @(posedge clock);
      while (bearing_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses in %0d cycles.",
               requests_sent, responses_checked, cycle_count);
      $display("Stimulus covered zero vectors, both axes, the coordinate extremes %s",
               "and half-turn errors.");
      if (mismatch_count == 0) begin
         $display("bearing_error_atan2_unit test passed");
      end else begin
         $display("bearing_error_atan2_unit test failed");
      end
      $finish;
   end

endmodule
